@@ design/ccwas_pkg.sv @@
`default_nettype none
package ccwas_pkg;
	localparam int XY_W   = 16;
	localparam int CNT_W  = 7;
	localparam int SUM_W  = 22;
	localparam int OFF_W  = 25;
	localparam int PROD_W = 2 * OFF_W;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_RDI,
		ST_OFFI,
		ST_RDJ,
		ST_OFFJ,
		ST_MUL1,
		ST_MUL2,
		ST_CMP,
		ST_SWA,
		ST_SWB,
		ST_ERD,
		ST_EOUT,
		ST_EWAIT
	} ccwas_state_t;
endpackage
`default_nettype wire

@@ design/ccw_centroid_angle_sort_unit.sv @@
// Collects up to MAX_POINTS signed points (one request per cycle while loading) and,
// on the request marked tlast, sorts them counterclockwise about their centroid and
// streams them out, the final one marked tlast. Points beyond capacity are dropped
// and every result of that set carries the overflow flag in tuser. Sorting is a
// selection sort on a point RAM with one write and one read port and one shared
// 25x25 multiplier for the cross product: each angle comparison steps through
// states RDJ, OFFJ, MUL1, MUL2 and CMP, and each result through ERD, EOUT and
// EWAIT; while a set is sorted or emitted, no new point is taken.
`default_nettype none
module ccw_centroid_angle_sort_unit #(
	parameter int MAX_POINTS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // in_x, in_y
	input  wire logic        s_tlast,  // in_last
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [31:0] m_tdata,  // out_x, out_y
	output logic             m_tlast,  // out_last
	output logic             m_tuser   // overflow
);
	import ccwas_pkg::*;

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);

	ccwas_state_t state_q, state_d;

	logic [CW-1:0] cnt_q, i_q, j_q, k_q, best_q;
	logic signed [SUM_W-1:0] sumx_q, sumy_q;
	logic drop_q;
	logic signed [OFF_W-1:0] bx_q, by_q, dx_q, dy_q;
	logic signed [PROD_W-1:0] prod1_q, prod2_q;
	logic [31:0] pi_q, pb_q, pj_q;
	logic mvalid_q, mlast_q, muser_q;
	logic [31:0] mdata_q;

	logic acc;
	logic ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [31:0] ram_wdata, ram_rdata;

	assign acc = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_LOAD);
	assign m_tvalid = mvalid_q;
	assign m_tdata = mdata_q;
	assign m_tlast = mlast_q;
	assign m_tuser = muser_q;

	ccwas_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// centroid offset of the point on the ram read port, scaled by n
	logic signed [CNT_W:0] n_s;
	logic signed [XY_W-1:0] rx, ry;
	logic signed [OFF_W-1:0] ox_raw, oy_raw, ox, oy;
	assign n_s = signed'({1'b0, CNT_W'(cnt_q)});
	assign rx = signed'(ram_rdata[15:0]);
	assign ry = signed'(ram_rdata[31:16]);
	assign ox_raw = OFF_W'(n_s * rx) - OFF_W'(sumx_q);
	assign oy_raw = OFF_W'(n_s * ry) - OFF_W'(sumy_q);
	always_comb begin
		ox = ox_raw;
		oy = oy_raw;
		if (ox_raw == '0 && oy_raw == '0) begin
			ox = OFF_W'(1);
		end
	end

	// shared multiplier
	logic signed [OFF_W-1:0] mul_a, mul_b;
	logic signed [PROD_W-1:0] prod;
	assign mul_a = (state_q == ST_MUL1) ? dx_q : dy_q;
	assign mul_b = (state_q == ST_MUL1) ? by_q : bx_q;
	assign prod = mul_a * mul_b;

	logic hd, hb, less;
	assign hd = !((dy_q > 0) || (dy_q == 0 && dx_q > 0));
	assign hb = !((by_q > 0) || (by_q == 0 && bx_q > 0));
	assign less = (hd != hb) ? (!hd && hb) : (prod1_q > prod2_q);

	logic [CW-1:0] i_inc, j_inc, k_inc;
	assign i_inc = i_q + CW'(1);
	assign j_inc = j_q + CW'(1);
	assign k_inc = k_q + CW'(1);

	always_comb begin
		state_d = state_q;
		ram_we = 1'b0;
		ram_waddr = cnt_q[AW-1:0];
		ram_wdata = s_tdata;
		ram_raddr = i_q[AW-1:0];
		unique case (state_q)
			ST_LOAD: begin
				ram_we = acc && (cnt_q < CW'(MAX_POINTS));
				if (acc && s_tlast) begin
					state_d = ST_RDI;
				end
			end
			ST_RDI:  state_d = ST_OFFI;
			ST_OFFI: state_d = (i_inc == cnt_q) ? ST_SWA : ST_RDJ;
			ST_RDJ: begin
				ram_raddr = j_q[AW-1:0];
				state_d = ST_OFFJ;
			end
			ST_OFFJ: state_d = ST_MUL1;
			ST_MUL1: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_CMP;
			ST_CMP:  state_d = (j_inc == cnt_q) ? ST_SWA : ST_RDJ;
			ST_SWA: begin
				ram_we = 1'b1;
				ram_waddr = i_q[AW-1:0];
				ram_wdata = pb_q;
				state_d = ST_SWB;
			end
			ST_SWB: begin
				ram_we = 1'b1;
				ram_waddr = best_q[AW-1:0];
				ram_wdata = pi_q;
				state_d = (i_inc == cnt_q) ? ST_ERD : ST_RDI;
			end
			ST_ERD: begin
				ram_raddr = k_q[AW-1:0];
				state_d = ST_EOUT;
			end
			ST_EOUT: state_d = ST_EWAIT;
			ST_EWAIT: begin
				if (m_tready) begin
					state_d = mlast_q ? ST_LOAD : ST_ERD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sumx_q <= '0;
			sumy_q <= '0;
			drop_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			best_q <= '0;
			mvalid_q <= 1'b0;
			mlast_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (acc) begin
						if (cnt_q < CW'(MAX_POINTS)) begin
							cnt_q <= cnt_q + CW'(1);
							sumx_q <= sumx_q + SUM_W'(signed'(s_tdata[15:0]));
							sumy_q <= sumy_q + SUM_W'(signed'(s_tdata[31:16]));
						end else begin
							drop_q <= 1'b1;
						end
						i_q <= '0;
					end
				end
				ST_OFFI: begin
					best_q <= i_q;
					j_q <= i_inc;
				end
				ST_CMP: begin
					if (less) begin
						best_q <= j_q;
					end
					j_q <= j_inc;
				end
				ST_SWB: begin
					i_q <= i_inc;
					k_q <= '0;
				end
				ST_EOUT: begin
					mvalid_q <= 1'b1;
					mlast_q <= (k_inc == cnt_q);
				end
				ST_EWAIT: begin
					if (m_tready) begin
						mvalid_q <= 1'b0;
						k_q <= k_inc;
						if (mlast_q) begin
							cnt_q <= '0;
							sumx_q <= '0;
							sumy_q <= '0;
							drop_q <= 1'b0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_OFFI: begin
				bx_q <= ox;
				by_q <= oy;
				pi_q <= ram_rdata;
				pb_q <= ram_rdata;
			end
			ST_OFFJ: begin
				dx_q <= ox;
				dy_q <= oy;
				pj_q <= ram_rdata;
			end
			ST_MUL1: prod1_q <= prod;
			ST_MUL2: prod2_q <= prod;
			ST_CMP: begin
				if (less) begin
					bx_q <= dx_q;
					by_q <= dy_q;
					pb_q <= pj_q;
				end
			end
			ST_EOUT: begin
				mdata_q <= ram_rdata;
				muser_q <= drop_q;
			end
			default: begin
			end
		endcase
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid) else $error("input taken while results pending");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_POINTS)) else $error("point count above capacity");

	a_set_clear: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> cnt_q == '0 && !drop_q)
		else $error("set state not cleared after last result");
endmodule
`default_nettype wire

@@ design/ccwas_ram.sv @@
`default_nettype none
module ccwas_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                                      clk,
	input  wire logic                                      we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                          wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                          rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire
